// ----- hdl/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, codes and default sizes for the chained hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  // Default table sizes.
  localparam int DEF_MAX_BUCKETS = 256;
  localparam int DEF_POOL_NODES  = 512;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;

  // Request modes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [VAL_W-1:0] found_value;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INIT,
    OP_RD_HEAD,
    OP_LD_HEAD,
    OP_RD_NODE,
    OP_STEP,
    OP_UNLINK,
    OP_RD_ALLOC,
    OP_INSERT,
    OP_G_RD,
    OP_G_LD,
    OP_G_APP,
    OP_G_END_LO,
    OP_G_END_HI
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_we;
    logic [1:0] res_status;
    logic       res_found;
    logic       res_use_val;
    logic       out_load;
  } cht_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cur_empty;
    logic       key_hit;
    logic       pool_full;
    logic       need_grow;
    logic       grow_last;
    logic       out_busy;
  } cht_stat_t;

endpackage

`default_nettype wire

// ----- hdl/cht_ctrl.sv -----
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: walks chains, allocates nodes and drives table growth.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cht_stat_t stat,
  output cht_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_L_RD, S_L_LD, S_NODE, S_CMP, S_I_RD, S_I_WR,
    S_G_RD, S_G_LD, S_G_NODE, S_G_APP, S_G_END_LO, S_G_END_HI, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_INSERT: begin
            if (stat.pool_full) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_POOL_FULL;
              state_nxt      = S_RESP;
            end else if (stat.need_grow) begin
              state_nxt = S_G_RD;
            end else begin
              state_nxt = S_I_RD;
            end
          end
          MODE_LOOKUP, MODE_REMOVE: state_nxt = S_L_RD;
          default: begin
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_L_RD: begin
        cmd.op    = OP_RD_HEAD;
        state_nxt = S_L_LD;
      end
      S_L_LD: begin
        cmd.op    = OP_LD_HEAD;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        if (stat.cur_empty) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          cmd.op    = OP_RD_NODE;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.key_hit) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_DONE;
          cmd.res_found  = 1'b1;
          if (stat.mode == MODE_LOOKUP) begin
            cmd.res_use_val = 1'b1;
          end else begin
            cmd.op = OP_UNLINK;
          end
          state_nxt = S_RESP;
        end else begin
          cmd.op    = OP_STEP;
          state_nxt = S_NODE;
        end
      end
      S_I_RD: begin
        cmd.op    = OP_RD_ALLOC;
        state_nxt = S_I_WR;
      end
      S_I_WR: begin
        cmd.op         = OP_INSERT;
        cmd.res_we     = 1'b1;
        cmd.res_status = ST_DONE;
        state_nxt      = S_RESP;
      end
      S_G_RD: begin
        cmd.op    = OP_G_RD;
        state_nxt = S_G_LD;
      end
      S_G_LD: begin
        cmd.op    = OP_G_LD;
        state_nxt = S_G_NODE;
      end
      S_G_NODE: begin
        if (stat.cur_empty) begin
          state_nxt = S_G_END_LO;
        end else begin
          cmd.op    = OP_RD_NODE;
          state_nxt = S_G_APP;
        end
      end
      S_G_APP: begin
        cmd.op    = OP_G_APP;
        state_nxt = S_G_NODE;
      end
      S_G_END_LO: begin
        cmd.op    = OP_G_END_LO;
        state_nxt = S_G_END_HI;
      end
      S_G_END_HI: begin
        cmd.op    = OP_G_END_HI;
        state_nxt = stat.grow_last ? S_I_RD : S_G_RD;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cht_dp.sv -----
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: bucket heads, node store, free lists, counters and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_dp
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int POOL_NODES  = DEF_POOL_NODES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_item_t     out_data,
  input  wire cht_cmd_t cmd,
  output cht_stat_t     stat
);

  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int LW = $clog2(BW + 1);
  localparam int TW = (NW > BW + 2) ? NW : BW + 2;
  localparam logic [NW-1:0] EMPTY = NW'(POOL_NODES);

  // Memories.
  logic [NW-1:0]    head_mem [MAX_BUCKETS];
  logic [KEY_W-1:0] key_mem  [POOL_NODES];
  logic [VAL_W-1:0] val_mem  [POOL_NODES];
  logic [NW-1:0]    link_mem [POOL_NODES];
  logic [AW-1:0]    rec_mem  [POOL_NODES];

  logic [NW-1:0]    head_q, link_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0]    rec_q;

  // Registers.
  in_item_t  req_r;
  logic [NW-1:0] cur_r, prev_r, lo_h_r, lo_t_r, hi_h_r, hi_t_r;
  logic [BW-1:0] gb_r;
  logic [LW-1:0] lg_r;
  logic [NW-1:0] elem_r, hw_r, rc_r;
  out_item_t res_r, out_r;
  logic      out_valid_r;

  // Derived values.
  logic [TW-1:0] total_w;
  logic [BW-1:0] bkt, gb_hi;
  logic [NW-1:0] rc_m1, new_node;
  logic          side_hi;

  assign total_w  = TW'(1) << lg_r;
  assign bkt      = req_r.key[BW-1:0] & BW'(total_w - TW'(1));
  assign gb_hi    = gb_r + BW'(total_w);
  assign rc_m1    = rc_r - NW'(1);
  assign new_node = (rc_r != '0) ? NW'(rec_q) : hw_r;
  assign side_hi  = key_q[lg_r];

  // Status back to the controller.
  always_comb begin
    stat.mode      = req_r.mode;
    stat.cur_empty = (cur_r == EMPTY);
    stat.key_hit   = (key_q == req_r.key);
    stat.pool_full = (rc_r == '0) && (hw_r == EMPTY);
    stat.need_grow = (TW'(elem_r) == total_w) &&
                     ((total_w << 1) <= TW'(MAX_BUCKETS));
    stat.grow_last = (TW'(gb_r) == total_w - TW'(1));
    stat.out_busy  = out_valid_r && !out_ready;
  end

  // Memory port selection.
  logic          head_we, link_we, node_we, rec_we;
  logic [BW-1:0] head_wa, head_ra;
  logic [NW-1:0] head_wd, link_wd;
  logic [AW-1:0] link_wa, node_wa;

  always_comb begin
    head_we = 1'b0;
    head_wa = bkt;
    head_wd = EMPTY;
    head_ra = bkt;
    link_we = 1'b0;
    link_wa = new_node[AW-1:0];
    link_wd = EMPTY;
    node_we = 1'b0;
    node_wa = new_node[AW-1:0];
    rec_we  = 1'b0;
    case (cmd.op)
      OP_INIT: begin
        head_we = 1'b1;
        head_wa = '0;
      end
      OP_G_RD: head_ra = gb_r;
      OP_UNLINK: begin
        if (prev_r == EMPTY) begin
          head_we = 1'b1;
          head_wd = link_q;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[AW-1:0];
          link_wd = link_q;
        end
        rec_we = 1'b1;
      end
      OP_INSERT: begin
        head_we = 1'b1;
        head_wd = new_node;
        link_we = 1'b1;
        link_wd = head_q;
        node_we = 1'b1;
      end
      OP_G_APP: begin
        link_wa = side_hi ? hi_t_r[AW-1:0] : lo_t_r[AW-1:0];
        link_wd = cur_r;
        link_we = side_hi ? (hi_t_r != EMPTY) : (lo_t_r != EMPTY);
      end
      OP_G_END_LO: begin
        head_we = 1'b1;
        head_wa = gb_r;
        head_wd = lo_h_r;
        link_we = (lo_t_r != EMPTY);
        link_wa = lo_t_r[AW-1:0];
      end
      OP_G_END_HI: begin
        head_we = 1'b1;
        head_wa = gb_hi;
        head_wd = hi_h_r;
        link_we = (hi_t_r != EMPTY);
        link_wa = hi_t_r[AW-1:0];
      end
      default: ;
    endcase
  end

  // Bucket head memory.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[head_ra];
  end

  // Node key, value and link memories, read at the current node.
  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[node_wa] <= req_r.key;
      val_mem[node_wa] <= req_r.value_word;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    key_q  <= key_mem[cur_r[AW-1:0]];
    val_q  <= val_mem[cur_r[AW-1:0]];
    link_q <= link_mem[cur_r[AW-1:0]];
  end

  // Stack of recycled nodes; fresh nodes come from the high-water count.
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rc_r[AW-1:0]] <= cur_r[AW-1:0];
    end
    rec_q <= rec_mem[rc_m1[AW-1:0]];
  end

  // Control counters and result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r        <= '0;
      elem_r      <= '0;
      hw_r        <= '0;
      rc_r        <= '0;
      gb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_UNLINK: begin
          rc_r   <= rc_r + NW'(1);
          elem_r <= elem_r - NW'(1);
        end
        OP_INSERT: begin
          elem_r <= elem_r + NW'(1);
          if (rc_r != '0) begin
            rc_r <= rc_m1;
          end else begin
            hw_r <= hw_r + NW'(1);
          end
        end
        OP_G_END_HI: begin
          if (stat.grow_last) begin
            gb_r <= '0;
            lg_r <= lg_r + LW'(1);
          end else begin
            gb_r <= gb_r + BW'(1);
          end
        end
        default: ;
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, walk pointers and growth lists.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: req_r <= in_data;
      OP_LD_HEAD: begin
        cur_r  <= head_q;
        prev_r <= EMPTY;
      end
      OP_STEP: begin
        prev_r <= cur_r;
        cur_r  <= link_q;
      end
      OP_G_LD: begin
        cur_r  <= head_q;
        lo_h_r <= EMPTY;
        lo_t_r <= EMPTY;
        hi_h_r <= EMPTY;
        hi_t_r <= EMPTY;
      end
      OP_G_APP: begin
        cur_r <= link_q;
        if (side_hi) begin
          if (hi_t_r == EMPTY) begin
            hi_h_r <= cur_r;
          end
          hi_t_r <= cur_r;
        end else begin
          if (lo_t_r == EMPTY) begin
            lo_h_r <= cur_r;
          end
          lo_t_r <= cur_r;
        end
      end
      default: ;
    endcase
    if (cmd.res_we) begin
      res_r.status      <= cmd.res_status;
      res_r.found       <= cmd.res_found;
      res_r.found_value <= cmd.res_use_val ? val_q : '0;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- hdl/chained_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Key/value table with separate chaining, node pool and doubling buckets.
// ----------------------------------------------------------------------------
// Usage: a request beat (mode, key, value_word) enters on in_valid/in_ready;
// exactly one result beat (status, found, found_value) leaves on
// out_valid/out_ready for each request, in request order.
// One request is worked on at a time, in these steps:
//   lookup or remove: the bucket head is read, then the chain is walked
//   node by node until the key matches or the chain ends,
//   insert: a recycled or fresh node is linked at its chain's head, after
//   a growth pass when the element count reaches the bucket count and the
//   doubled count fits MAX_BUCKETS (each old chain is split in two).
// The next request is accepted in the cycle after its predecessor's result
// is loaded. The chain walk through the node memory sets the rate. The
// result sits in an output register; a new request is accepted while it
// waits, and the next result waits until out_ready takes the old one.
// After reset (rst_n low, synchronous) S_INIT clears the single bucket,
// then in_ready rises. Reset empties the table and refills the node pool.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int POOL_NODES  = DEF_POOL_NODES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  cht_cmd_t  cmd;
  cht_stat_t stat;

  // Sequencer.
  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table storage and arithmetic.
  cht_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_NODES  (POOL_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ----- hdl/cht_checker.sv -----
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_checker
  import cht_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Requests accepted whose result beat has not yet left.
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Every result beat answers an accepted request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without a pending request");

  // At most one request in work and one result waiting.
  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // A value is only returned with a match.
  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.found_value != '0) |->
      out_data.found && (out_data.status == ST_DONE))
    else $error("value returned without a match");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);

`default_nettype wire
